// File: rtl/core/spgr_pkg.sv
`default_nettype none

package spgr_pkg;

	localparam int SAMPLES_PER_AVERAGE = 10;

	localparam int CMD_W = 3;
	localparam int POT_W = 12;
	localparam int PERIOD_W = 10;
	localparam int COUNT_W = 32;
	localparam int SUM_W = 16;
	localparam int SNUM_W = 4;
	localparam int CFG_IDX_W = 1;
	localparam int CFG_DATA_W = 10;

	localparam logic [PERIOD_W-1:0] SLOW_PERIOD_US = 10'd1000;
	localparam logic [PERIOD_W-1:0] FAST_PERIOD_US = 10'd200;
	localparam logic [PERIOD_W-1:0] SPAN_US = SLOW_PERIOD_US - FAST_PERIOD_US;
	localparam logic [PERIOD_W-1:0] RESET_ACCEL_US = 10'd10;
	localparam logic [POT_W-1:0] POT_FULL = {POT_W{1'b1}};

	// Exact division of the sample sum by a reciprocal multiply.
	localparam int AVG_SHIFT = SUM_W + $clog2(SAMPLES_PER_AVERAGE);
	localparam int AVG_MUL = (2 ** AVG_SHIFT + SAMPLES_PER_AVERAGE - 1) / SAMPLES_PER_AVERAGE;
	localparam int AVG_MUL_W = SUM_W + 2;
	localparam int AVG_PROD_W = SUM_W + AVG_MUL_W;
	localparam int SCALED_W = POT_W + PERIOD_W;

	typedef enum logic [CMD_W-1:0] {
		CMD_TICK   = 3'd0,
		CMD_RAMP   = 3'd1,
		CMD_SAMPLE = 3'd2,
		CMD_RUN    = 3'd3,
		CMD_STOP   = 3'd4,
		CMD_CLEAR  = 3'd5
	} cmd_e_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_ACCEL_STEP   = 1'd0,
		REG_START_PERIOD = 1'd1
	} reg_idx_t;

	typedef struct packed {
		logic [CMD_W-1:0] command;
		logic [POT_W-1:0] pot_sample;
	} item_t;

	typedef struct packed {
		logic                step_level;
		logic [COUNT_W-1:0]  step_count;
		logic [PERIOD_W-1:0] step_period_us;
		logic [PERIOD_W-1:0] target_period_us;
		logic                running;
	} result_t;

endpackage

`default_nettype wire

// File: rtl/core/spgr_in_stage.sv
`default_nettype none

module spgr_in_stage
	import spgr_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_valid,
	output logic                  in_ready,
	input  wire logic [CMD_W-1:0] command,
	input  wire logic [POT_W-1:0] pot_sample,
	input  wire logic             advance,
	output logic                  valid_s1,
	output item_t                 item_s1
);

	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1.command    <= command;
			item_s1.pot_sample <= pot_sample;
		end
	end

endmodule

`default_nettype wire

// File: rtl/core/spgr_core.sv
`default_nettype none

module spgr_core
	import spgr_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  fire,
	input  wire item_t                 item_s1,
	input  wire logic                  cfg_fire,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data,
	output result_t                    result_next
);

	logic [PERIOD_W-1:0] half_cnt_q;
	logic                pin_q;
	logic [COUNT_W-1:0]  toggle_cnt_q;
	logic [PERIOD_W-1:0] cur_period_q;
	logic [PERIOD_W-1:0] goal_period_q;
	logic [SUM_W-1:0]    sum_q;
	logic [SNUM_W-1:0]   snum_q;
	logic                step_en_q;
	logic                pot_en_q;
	logic [PERIOD_W-1:0] accel_q;

	logic [PERIOD_W-1:0] half_cnt_d;
	logic                pin_d;
	logic [COUNT_W-1:0]  toggle_cnt_d;
	logic [PERIOD_W-1:0] cur_period_d;
	logic [PERIOD_W-1:0] goal_period_d;
	logic [SUM_W-1:0]    sum_d;
	logic [SNUM_W-1:0]   snum_d;
	logic                step_en_d;
	logic                pot_en_d;

	logic [PERIOD_W-2:0]   half_raw;
	logic [PERIOD_W-1:0]   half_eff;
	logic [PERIOD_W:0]     cnt_inc;
	logic                  tick_wrap;
	logic [PERIOD_W-1:0]   gap;
	logic [SUM_W-1:0]      sum_add;
	logic [SNUM_W:0]       snum_inc;
	logic                  avg_done;
	logic [AVG_PROD_W-1:0] avg_prod;
	logic [SUM_W-1:0]      avg_raw;
	logic [POT_W-1:0]      avg_clamped;
	logic [SCALED_W-1:0]   scaled;
	logic [SCALED_W:0]     scaled_adj;
	logic [PERIOD_W-1:0]   drop;

	always_comb begin
		half_raw  = cur_period_q[PERIOD_W-1:1];
		half_eff  = (half_raw == '0) ? PERIOD_W'(1) : {1'b0, half_raw};
		cnt_inc   = {1'b0, half_cnt_q} + (PERIOD_W+1)'(1);
		tick_wrap = cnt_inc >= {1'b0, half_eff};

		if (goal_period_q < cur_period_q) begin
			gap = cur_period_q - goal_period_q;
		end else begin
			gap = goal_period_q - cur_period_q;
		end

		sum_add     = sum_q + SUM_W'(item_s1.pot_sample);
		snum_inc    = {1'b0, snum_q} + (SNUM_W+1)'(1);
		avg_done    = snum_inc >= (SNUM_W+1)'(SAMPLES_PER_AVERAGE);
		avg_prod    = AVG_PROD_W'(sum_add) * AVG_PROD_W'(AVG_MUL);
		avg_raw     = SUM_W'(avg_prod >> AVG_SHIFT);
		avg_clamped = (avg_raw > SUM_W'(POT_FULL)) ? POT_FULL : avg_raw[POT_W-1:0];
		scaled      = SCALED_W'(avg_clamped) * SCALED_W'(SPAN_US);
		// Division by 2^12 - 1, exact for values below 2^24.
		scaled_adj  = {1'b0, scaled} + (SCALED_W+1)'(scaled >> POT_W) + (SCALED_W+1)'(1);
		drop        = PERIOD_W'(scaled_adj >> POT_W);

		half_cnt_d    = half_cnt_q;
		pin_d         = pin_q;
		toggle_cnt_d  = toggle_cnt_q;
		cur_period_d  = cur_period_q;
		goal_period_d = goal_period_q;
		sum_d         = sum_q;
		snum_d        = snum_q;
		step_en_d     = step_en_q;
		pot_en_d      = pot_en_q;

		case (item_s1.command)
			CMD_TICK: begin
				if (step_en_q) begin
					if (tick_wrap) begin
						half_cnt_d   = '0;
						pin_d        = !pin_q;
						toggle_cnt_d = toggle_cnt_q + COUNT_W'(1);
					end else begin
						half_cnt_d = cnt_inc[PERIOD_W-1:0];
					end
				end
			end
			CMD_RAMP: begin
				if (goal_period_q < cur_period_q) begin
					cur_period_d = (gap > accel_q) ? cur_period_q - accel_q : goal_period_q;
				end else if (goal_period_q > cur_period_q) begin
					cur_period_d = (gap > accel_q) ? cur_period_q + accel_q : goal_period_q;
				end
			end
			CMD_SAMPLE: begin
				if (pot_en_q) begin
					if (avg_done) begin
						goal_period_d = SLOW_PERIOD_US - drop;
						sum_d         = '0;
						snum_d        = '0;
					end else begin
						sum_d  = sum_add;
						snum_d = snum_inc[SNUM_W-1:0];
					end
				end
			end
			CMD_RUN: begin
				step_en_d = 1'b1;
				pot_en_d  = 1'b1;
			end
			CMD_STOP: begin
				step_en_d = 1'b0;
				pot_en_d  = 1'b0;
			end
			CMD_CLEAR: begin
				toggle_cnt_d = '0;
			end
			default: begin
			end
		endcase

		result_next.step_level       = pin_d;
		result_next.step_count       = toggle_cnt_d;
		result_next.step_period_us   = cur_period_d;
		result_next.target_period_us = goal_period_d;
		result_next.running          = step_en_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			half_cnt_q    <= '0;
			pin_q         <= 1'b0;
			toggle_cnt_q  <= '0;
			cur_period_q  <= SLOW_PERIOD_US;
			goal_period_q <= SLOW_PERIOD_US;
			sum_q         <= '0;
			snum_q        <= '0;
			step_en_q     <= 1'b1;
			pot_en_q      <= 1'b0;
			accel_q       <= RESET_ACCEL_US;
		end else if (fire) begin
			half_cnt_q    <= half_cnt_d;
			pin_q         <= pin_d;
			toggle_cnt_q  <= toggle_cnt_d;
			cur_period_q  <= cur_period_d;
			goal_period_q <= goal_period_d;
			sum_q         <= sum_d;
			snum_q        <= snum_d;
			step_en_q     <= step_en_d;
			pot_en_q      <= pot_en_d;
		end else if (cfg_fire) begin
			case (cfg_index)
				REG_ACCEL_STEP: begin
					accel_q <= cfg_data;
				end
				REG_START_PERIOD: begin
					cur_period_q  <= cfg_data;
					goal_period_q <= cfg_data;
				end
				default: begin
				end
			endcase
		end
	end

	a_sample_number_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(SNUM_W+1)'(snum_q) < (SNUM_W+1)'(SAMPLES_PER_AVERAGE))
		else $error("sample number reached the averaging length");

	a_toggle_clears_counter: assert property (@(posedge clk) disable iff (!arst_n)
		(pin_q != $past(pin_q)) |-> (half_cnt_q == '0))
		else $error("step level toggled without clearing the half-period counter");

	a_tick_when_stopped: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && item_s1.command == CMD_TICK && !step_en_q)
			|=> ($stable(pin_q) && $stable(toggle_cnt_q)))
		else $error("stopped generator changed the step output");

	a_run_enables: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && item_s1.command == CMD_RUN) |=> (step_en_q && pot_en_q))
		else $error("run command did not enable stepping and speed input");

endmodule

`default_nettype wire

// File: rtl/core/spgr_out_stage.sv
`default_nettype none

module spgr_out_stage
	import spgr_pkg::*;
(
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    fire,
	input  wire result_t result_next,
	input  wire logic    out_ready,
	output logic         out_valid,
	output logic         advance,
	output result_t      result_q
);

	logic out_valid_q;

	assign advance   = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= fire;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			result_q <= result_next;
		end
	end

endmodule

`default_nettype wire

// File: rtl/core/stepper_pulse_generator_with_ramp_top.sv
// Step pulse generator with a linear speed ramp.
// Input channel: in_valid/in_ready carry one command per transfer (microsecond
// tick, ramp tick, potentiometer sample, run, stop, clear count) with its sample.
// Output channel: out_valid/out_ready carry one result per command, holding the
// step level, toggle count, current and target period, and the running flag
// as they stand after that command.
// Configuration channel: cfg_valid/cfg_ready write the acceleration step
// (index 0) or the start period (index 1); writing the start period also loads
// the current and target period. cfg_ready is always high. Write only while
// no command is in flight.
// Each command passes through the input register and the state update into the
// result register, where its result waits until the receiver takes it.
// Throughput is one command per cycle while out_ready stays high, set by the
// single state-update pass between the input register and the result register.
// Reset clears the valid flags of both pipeline registers, loads a 1000 us period
// and target, a 10 us acceleration step, stepping on and speed input off.
// When the receiver stalls, the result register holds and in_ready drops once
// the input register is also full; no command is lost.
`default_nettype none

module stepper_pulse_generator_with_ramp_top
	import spgr_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  in_valid,
	output logic                       in_ready,
	input  wire logic [CMD_W-1:0]      command,
	input  wire logic [POT_W-1:0]      pot_sample,
	output logic                       out_valid,
	input  wire logic                  out_ready,
	output logic                       step_level,
	output logic [COUNT_W-1:0]         step_count,
	output logic [PERIOD_W-1:0]        step_period_us,
	output logic [PERIOD_W-1:0]        target_period_us,
	output logic                       running,
	input  wire logic                  cfg_valid,
	output logic                       cfg_ready,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data
);

	logic    valid_s1;
	item_t   item_s1;
	logic    advance;
	logic    fire;
	result_t result_next;
	result_t result_q;

	assign cfg_ready = 1'b1;
	assign fire      = valid_s1 && advance;

	spgr_in_stage u_in_stage (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.command    (command),
		.pot_sample (pot_sample),
		.advance    (advance),
		.valid_s1   (valid_s1),
		.item_s1    (item_s1)
	);

	spgr_core u_core (
		.clk         (clk),
		.arst_n      (arst_n),
		.fire        (fire),
		.item_s1     (item_s1),
		.cfg_fire    (cfg_valid && cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.result_next (result_next)
	);

	spgr_out_stage u_out_stage (
		.clk         (clk),
		.arst_n      (arst_n),
		.fire        (fire),
		.result_next (result_next),
		.out_ready   (out_ready),
		.out_valid   (out_valid),
		.advance     (advance),
		.result_q    (result_q)
	);

	assign step_level       = result_q.step_level;
	assign step_count       = result_q.step_count;
	assign step_period_us   = result_q.step_period_us;
	assign target_period_us = result_q.target_period_us;
	assign running          = result_q.running;

endmodule

`default_nettype wire

// File: test/spgr_status_checker.sv
module spgr_status_checker
	import spgr_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  in_valid,
	input  wire logic                  in_ready,
	input  wire logic [CMD_W-1:0]      command,
	input  wire logic [POT_W-1:0]      pot_sample,
	input  wire logic                  out_valid,
	input  wire logic                  out_ready,
	input  wire logic                  step_level,
	input  wire logic [COUNT_W-1:0]    step_count,
	input  wire logic [PERIOD_W-1:0]   step_period_us,
	input  wire logic [PERIOD_W-1:0]   target_period_us,
	input  wire logic                  running,
	input  wire logic                  cfg_valid,
	input  wire logic                  cfg_ready,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data,
	output int                         error_count,
	output int                         results_owed
);
	timeunit 1ns;
	timeprecision 1ps;

	logic [PERIOD_W-1:0] accel_us;
	logic [PERIOD_W-1:0] half_ctr;
	logic [PERIOD_W-1:0] cur_period;
	logic [PERIOD_W-1:0] goal_period;
	logic                pin;
	logic [COUNT_W-1:0]  toggles;
	logic [SUM_W-1:0]    pot_sum;
	logic [SNUM_W-1:0]   pot_count;
	logic                step_on;
	logic                pot_on;

	result_t status_q[$];
	result_t want;
	int      errors;

	task automatic report(input string what, input longint unsigned want_v,
			input longint unsigned got_v);
		errors++;
		if (errors <= 10) begin
			$display("%0t: %s mismatch, expected %0d, got %0d", $realtime, what, want_v, got_v);
		end
	endtask

	// Applies one command to the local copy of the generator state and returns
	// the status that the block must show afterwards.
	function automatic result_t advance_stepper(input logic [CMD_W-1:0] cmd,
			input logic [POT_W-1:0] pot);
		result_t             status;
		logic [PERIOD_W-1:0] half;
		int                  mean;
		case (cmd)
			CMD_TICK: begin
				if (step_on) begin
					half = cur_period >> 1;
					if (half == '0) begin
						half = PERIOD_W'(1);
					end
					if (int'(half_ctr) + 1 >= int'(half)) begin
						half_ctr = '0;
						pin = ~pin;
						toggles = toggles + COUNT_W'(1);
					end else begin
						half_ctr = half_ctr + PERIOD_W'(1);
					end
				end
			end
			CMD_RAMP: begin
				if (goal_period < cur_period) begin
					if (cur_period - goal_period > accel_us) begin
						cur_period = cur_period - accel_us;
					end else begin
						cur_period = goal_period;
					end
				end else if (goal_period > cur_period) begin
					if (goal_period - cur_period > accel_us) begin
						cur_period = cur_period + accel_us;
					end else begin
						cur_period = goal_period;
					end
				end
			end
			CMD_SAMPLE: begin
				if (pot_on) begin
					pot_sum = pot_sum + SUM_W'(pot);
					if (int'(pot_count) + 1 >= SAMPLES_PER_AVERAGE) begin
						mean = int'(pot_sum) / SAMPLES_PER_AVERAGE;
						if (mean > int'(POT_FULL)) begin
							mean = int'(POT_FULL);
						end
						goal_period = PERIOD_W'(int'(SLOW_PERIOD_US)
								- mean * int'(SPAN_US) / int'(POT_FULL));
						pot_sum = '0;
						pot_count = '0;
					end else begin
						pot_count = pot_count + SNUM_W'(1);
					end
				end
			end
			CMD_RUN: begin
				step_on = 1'b1;
				pot_on = 1'b1;
			end
			CMD_STOP: begin
				step_on = 1'b0;
				pot_on = 1'b0;
			end
			CMD_CLEAR: begin
				toggles = '0;
			end
			default: begin
			end
		endcase
		status.step_level = pin;
		status.step_count = toggles;
		status.step_period_us = cur_period;
		status.target_period_us = goal_period;
		status.running = step_on;
		return status;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			accel_us = RESET_ACCEL_US;
			half_ctr = '0;
			cur_period = SLOW_PERIOD_US;
			goal_period = SLOW_PERIOD_US;
			pin = 1'b0;
			toggles = '0;
			pot_sum = '0;
			pot_count = '0;
			step_on = 1'b1;
			pot_on = 1'b0;
			status_q.delete();
			errors = 0;
			error_count <= 0;
			results_owed <= 0;
		end else begin
			if (out_valid && out_ready) begin
				if (status_q.size() == 0) begin
					errors++;
					if (errors <= 10) begin
						$display("%0t: result transfer with no command outstanding", $realtime);
					end
				end else begin
					want = status_q.pop_front();
					if (step_level !== want.step_level) begin
						report("step_level", want.step_level, step_level);
					end
					if (step_count !== want.step_count) begin
						report("step_count", want.step_count, step_count);
					end
					if (step_period_us !== want.step_period_us) begin
						report("step_period_us", want.step_period_us, step_period_us);
					end
					if (target_period_us !== want.target_period_us) begin
						report("target_period_us", want.target_period_us, target_period_us);
					end
					if (running !== want.running) begin
						report("running", want.running, running);
					end
				end
			end
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == REG_ACCEL_STEP) begin
					accel_us = cfg_data;
				end else if (cfg_index == REG_START_PERIOD) begin
					cur_period = cfg_data;
					goal_period = cfg_data;
				end
			end
			if (in_valid && in_ready) begin
				status_q.push_back(advance_stepper(command, pot_sample));
			end
			error_count <= errors;
			results_owed <= status_q.size();
		end
	end

endmodule

// File: test/stepper_pulse_generator_with_ramp_top_tb.sv
module stepper_pulse_generator_with_ramp_top_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import spgr_pkg::*;

	localparam int CYCLE_LIMIT = 300000;
	localparam int BURST_ITEMS = 150;
	localparam logic [CMD_W-1:0] CMD_SPARE_LO = 3'd6;
	localparam logic [CMD_W-1:0] CMD_SPARE_HI = 3'd7;

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  in_valid;
	logic                  in_ready;
	logic [CMD_W-1:0]      command;
	logic [POT_W-1:0]      pot_sample;
	logic                  out_valid;
	logic                  out_ready;
	logic                  step_level;
	logic [COUNT_W-1:0]    step_count;
	logic [PERIOD_W-1:0]   step_period_us;
	logic [PERIOD_W-1:0]   target_period_us;
	logic                  running;
	logic                  cfg_valid;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	int mismatches;
	int owed;
	int gap_pct;
	int stall_pct;
	int cycles = 0;
	logic [POT_W-1:0] knob;

	// A negative entry asks for a random legal value.
	int accel_set[8] = '{800, 1, 0, -1, 50, 800, 10, -1};
	int start_set[8] = '{1000, 200, 600, -1, 1, 0, 1000, -1};

	stepper_pulse_generator_with_ramp_top u_dut (
		.clk              (clk),
		.arst_n           (arst_n),
		.in_valid         (in_valid),
		.in_ready         (in_ready),
		.command          (command),
		.pot_sample       (pot_sample),
		.out_valid        (out_valid),
		.out_ready        (out_ready),
		.step_level       (step_level),
		.step_count       (step_count),
		.step_period_us   (step_period_us),
		.target_period_us (target_period_us),
		.running          (running),
		.cfg_valid        (cfg_valid),
		.cfg_ready        (cfg_ready),
		.cfg_index        (cfg_index),
		.cfg_data         (cfg_data)
	);

	spgr_status_checker u_status_check (
		.clk              (clk),
		.arst_n           (arst_n),
		.in_valid         (in_valid),
		.in_ready         (in_ready),
		.command          (command),
		.pot_sample       (pot_sample),
		.out_valid        (out_valid),
		.out_ready        (out_ready),
		.step_level       (step_level),
		.step_count       (step_count),
		.step_period_us   (step_period_us),
		.target_period_us (target_period_us),
		.running          (running),
		.cfg_valid        (cfg_valid),
		.cfg_ready        (cfg_ready),
		.cfg_index        (cfg_index),
		.cfg_data         (cfg_data),
		.error_count      (mismatches),
		.results_owed     (owed)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		out_ready <= ($urandom_range(99) >= stall_pct);
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("stepper_pulse_generator_with_ramp_top test failed");
			$finish;
		end
	end

	// Leaves in_valid high after the transfer so back-to-back commands need no
	// extra assignment at the same edge.
	task automatic push_command(input logic [CMD_W-1:0] cmd, input logic [POT_W-1:0] pot);
		while ($urandom_range(99) < gap_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		command <= cmd;
		pot_sample <= pot;
		do @(posedge clk); while (!in_ready);
	endtask

	task automatic drain;
		in_valid <= 1'b0;
		@(posedge clk);
		while (owed != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input reg_idx_t idx, input logic [CFG_DATA_W-1:0] val);
		drain();
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
	endtask

	task automatic random_burst(input int n);
		int i;
		int roll;
		logic [CMD_W-1:0] cmd;
		logic [POT_W-1:0] pot;
		for (i = 0; i < n; i++) begin
			roll = $urandom_range(99);
			if (roll < 45) begin
				cmd = CMD_TICK;
			end else if (roll < 60) begin
				cmd = CMD_RAMP;
			end else if (roll < 85) begin
				cmd = CMD_SAMPLE;
			end else if (roll < 90) begin
				cmd = CMD_RUN;
			end else if (roll < 93) begin
				cmd = CMD_STOP;
			end else if (roll < 96) begin
				cmd = CMD_CLEAR;
			end else begin
				cmd = $urandom_range(1) ? CMD_SPARE_HI : CMD_SPARE_LO;
			end
			if ($urandom_range(9) == 0) begin
				knob = POT_W'($urandom_range(4095));
			end
			roll = $urandom_range(9);
			if (roll == 0) begin
				pot = '0;
			end else if (roll == 1) begin
				pot = '1;
			end else if (roll < 4) begin
				pot = POT_W'($urandom_range(4095));
			end else begin
				pot = knob;
			end
			push_command(cmd, pot);
		end
	endtask

	initial begin
		int mode;
		int s;
		arst_n <= 1'b0;
		in_valid <= 1'b0;
		command <= CMD_TICK;
		pot_sample <= '0;
		out_ready <= 1'b0;
		cfg_valid <= 1'b0;
		cfg_index <= REG_ACCEL_STEP;
		cfg_data <= '0;
		stall_pct <= 0;
		gap_pct = 0;
		knob = '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset settings: spare codes, stopped commands, a sample with the speed
		// input off, then a full average of top readings after run.
		push_command(CMD_CLEAR, '0);
		push_command(CMD_TICK, '1);
		push_command(CMD_RAMP, '0);
		push_command(CMD_SAMPLE, '1);
		push_command(CMD_SPARE_LO, 12'h5A5);
		push_command(CMD_SPARE_HI, 12'hA5A);
		push_command(CMD_STOP, '0);
		push_command(CMD_TICK, '0);
		push_command(CMD_SAMPLE, '0);
		push_command(CMD_RUN, '0);
		repeat (SAMPLES_PER_AVERAGE) push_command(CMD_SAMPLE, '1);
		push_command(CMD_RAMP, '0);
		push_command(CMD_TICK, '0);
		push_command(CMD_CLEAR, '0);

		for (mode = 0; mode < 4; mode++) begin
			case (mode)
				0: begin
					gap_pct = 0;
					stall_pct <= 0;
				end
				1: begin
					gap_pct = 83;
					stall_pct <= 0;
				end
				2: begin
					gap_pct = 0;
					stall_pct <= 83;
				end
				default: begin
					gap_pct = 31;
					stall_pct <= 31;
				end
			endcase
			for (s = 2 * mode; s < 2 * mode + 2; s++) begin
				write_reg(REG_ACCEL_STEP, (accel_set[s] < 0) ?
						CFG_DATA_W'($urandom_range(1, 800)) : CFG_DATA_W'(accel_set[s]));
				write_reg(REG_START_PERIOD, (start_set[s] < 0) ?
						CFG_DATA_W'($urandom_range(200, 1000)) : CFG_DATA_W'(start_set[s]));
				random_burst(BURST_ITEMS);
			end
		end

		drain();
		repeat (10) @(posedge clk);
		if (mismatches == 0) begin
			$display("stepper_pulse_generator_with_ramp_top test passed");
		end else begin
			$display("stepper_pulse_generator_with_ramp_top test failed");
		end
		$finish;
	end

endmodule
